### hw/rtl/psc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psc_pkg
// shared widths, constants and the arctangent table of the steering block
// ----------------------------------------------------------------------------
package psc_pkg;

   // field widths
   localparam int POS_W    = 16;   // Q5.10 position
   localparam int ANG_W    = 16;   // Q3.12 angle
   localparam int CFG_W    = 15;   // configuration registers
   localparam int CSR_IDX_W = 2;
   localparam int DIFF_W   = POS_W + 1;  // difference vector component
   localparam int SCALE_SH = 8;          // difference scaled by 2^8 before rotation
   localparam int CX_W     = 28;         // rotation x/y datapath, signed
   localparam int Z_W      = 24;         // angle accumulator, Q.20 signed
   localparam int GAIN_W   = 16;
   localparam int PROD_W   = CX_W - 1 + GAIN_W;
   localparam int LEN_SH   = 24;
   localparam int LEN_W    = PROD_W - LEN_SH;
   localparam int WRAP_W   = ANG_W + 2;  // heading error before wrapping

   localparam int CORDIC_ITERATIONS_DEF = 14;
   localparam int ATAN_DEPTH = 24;
   localparam int ATAN_IDX_W = 5;

   // constants
   localparam logic [GAIN_W-1:0]        INV_GAIN_Q16 = 16'd39797;
   localparam logic signed [Z_W-1:0]    HALF_PI_Q20  = 24'sd1647099;
   localparam logic signed [Z_W-1:0]    ANG_ROUND    = 24'sd128;
   localparam logic [PROD_W-1:0]        LEN_ROUND    = PROD_W'(64'd1 << (LEN_SH - 1));
   localparam logic signed [WRAP_W-1:0] PI_Q12       = 18'sd12868;
   localparam logic signed [WRAP_W-1:0] TWO_PI_Q12   = 18'sd25736;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_DISTANCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINEAR_LIMIT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGULAR_LIMIT = 2'd2;

   // reset values
   localparam logic [CFG_W-1:0]        STOP_DISTANCE_RST = 15'd1024;
   localparam logic [CFG_W-1:0]        LINEAR_LIMIT_RST  = 15'd2048;
   localparam logic [CFG_W-1:0]        ANGULAR_LIMIT_RST = 15'd8192;
   localparam logic signed [POS_W-1:0] OWN_POS_RST       = 16'sd1024;
   localparam logic signed [ANG_W-1:0] OWN_HEADING_RST   = 16'sd0;

   // status of the rotation unit
   typedef struct packed {
      logic busy;
      logic done;
   } cordic_status_type;

   // atan(2^-i) in Q.20
   function automatic logic [20:0] atan_q20(input logic [ATAN_IDX_W-1:0] idx);
      logic [20:0] val;
      case (idx)
         5'd0:    val = 21'd823550;
         5'd1:    val = 21'd486170;
         5'd2:    val = 21'd256879;
         5'd3:    val = 21'd130396;
         5'd4:    val = 21'd65451;
         5'd5:    val = 21'd32757;
         5'd6:    val = 21'd16383;
         5'd7:    val = 21'd8192;
         5'd8:    val = 21'd4096;
         5'd9:    val = 21'd2048;
         5'd10:   val = 21'd1024;
         5'd11:   val = 21'd512;
         5'd12:   val = 21'd256;
         5'd13:   val = 21'd128;
         5'd14:   val = 21'd64;
         5'd15:   val = 21'd32;
         5'd16:   val = 21'd16;
         5'd17:   val = 21'd8;
         5'd18:   val = 21'd4;
         5'd19:   val = 21'd2;
         5'd20:   val = 21'd1;
         default: val = 21'd0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/pursuit_steering_command.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pursuit_steering_command
// go-to-target proportional steering: speed and turn rate toward a target
// ----------------------------------------------------------------------------
// usage
//   req channel (valid/ready): req_operation 0 stores the own pose
//   (req_pos_x, req_pos_y, req_heading) and gives no response; 1 takes
//   req_pos_x/req_pos_y as a target and gives one rsp transfer
//   rsp channel (valid/ready): linear speed, angular speed, stop flag
//   csr port: csr_we writes csr_wdata into the register at csr_index
//   (0 stop distance, 1 linear limit, 2 angular limit, others ignored)
// sequencing
//   a pose update is stored at its transfer; a target passes through the
//   load, rotation, scale and wrap steps to a valid response, the rotation
//   done by the shift-add rotator that runs one iteration per cycle
//   req_ready is high only while the sequencer is idle, so no new request
//   is taken until the previous target has left the final step
// reset
//   synchronous, clears the sequencer and the response valid, loads the
//   register defaults and an own pose of (1.0, 1.0) heading 0
// stalls
//   the response sits in an output register; pose updates are still taken
//   while it waits, a new target finishes its rotation and then holds in
//   the final step until the response register is free
// ----------------------------------------------------------------------------
module pursuit_steering_command #(
   parameter int CORDIC_ITERATIONS = psc_pkg::CORDIC_ITERATIONS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_operation,
   input  wire logic signed [psc_pkg::POS_W-1:0]    req_pos_x,
   input  wire logic signed [psc_pkg::POS_W-1:0]    req_pos_y,
   input  wire logic signed [psc_pkg::ANG_W-1:0]    req_heading,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [psc_pkg::CFG_W-1:0]                rsp_linear_speed,
   output logic signed [psc_pkg::ANG_W-1:0]         rsp_angular_speed,
   output logic                                     rsp_stopped,
   // configuration
   input  wire logic                                csr_we,
   input  wire logic [psc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [psc_pkg::CFG_W-1:0]           csr_wdata
);

   // sequencer states
   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_LOAD   = 5'b00010,
      S_CORDIC = 5'b00100,
      S_SCALE  = 5'b01000,
      S_WRAP   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [psc_pkg::CFG_W-1:0] stop_distance_ff, linear_limit_ff, angular_limit_ff;

   // own pose
   logic signed [psc_pkg::POS_W-1:0] own_x_ff, own_y_ff;
   logic signed [psc_pkg::ANG_W-1:0] own_heading_ff;

   // datapath registers
   logic signed [psc_pkg::DIFF_W-1:0] dx_ff, dy_ff;
   logic                              dzero_ff;
   logic [psc_pkg::PROD_W-1:0]        prod_ff;
   logic signed [psc_pkg::ANG_W-1:0]  bearing_ff;
   logic [psc_pkg::LEN_W-1:0]         len_ff;
   logic signed [psc_pkg::WRAP_W-1:0] diff_ff;

   // response registers
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [psc_pkg::CFG_W-1:0]         rsp_lin_ff, rsp_lin_in;
   logic signed [psc_pkg::ANG_W-1:0]  rsp_ang_ff, rsp_ang_in;
   logic                              rsp_stop_ff, rsp_stop_in;

   // combinational helpers
   logic                              req_xfer, out_free, cordic_start;
   logic signed [psc_pkg::DIFF_W-1:0] dx_in, dy_in;
   logic [psc_pkg::PROD_W-1:0]        prod_in, len_sum;
   logic signed [psc_pkg::Z_W-1:0]    z_round;
   logic signed [psc_pkg::ANG_W-1:0]  bearing_in;
   logic signed [psc_pkg::WRAP_W-1:0] diff_in, w1, w2, w3, w4, lim, clamped;

   psc_pkg::cordic_status_type        cordic_status;
   logic [psc_pkg::CX_W-2:0]          cordic_x;
   logic signed [psc_pkg::Z_W-1:0]    cordic_z;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cordic_start = (state_ff == S_LOAD);

   // difference vector, formed at the request transfer
   assign dx_in = psc_pkg::DIFF_W'(req_pos_x) - psc_pkg::DIFF_W'(own_x_ff);
   assign dy_in = psc_pkg::DIFF_W'(req_pos_y) - psc_pkg::DIFF_W'(own_y_ff);

   psc_cordic #(
      .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_start),
      .dx     (dx_ff),
      .dy     (dy_ff),
      .status (cordic_status),
      .x_mag  (cordic_x),
      .z_out  (cordic_z)
   );

   // gain correction and bearing rounding (round half up, Q.20 to Q3.12)
   assign prod_in    = psc_pkg::PROD_W'(cordic_x) * psc_pkg::PROD_W'(psc_pkg::INV_GAIN_Q16);
   assign z_round    = cordic_z + psc_pkg::ANG_ROUND;
   assign bearing_in = dzero_ff ? '0 : z_round[psc_pkg::Z_W-1:psc_pkg::SCALE_SH];

   // length and raw heading error
   assign len_sum = prod_ff + psc_pkg::LEN_ROUND;
   assign diff_in = psc_pkg::WRAP_W'(bearing_ff) - psc_pkg::WRAP_W'(own_heading_ff);

   // wrap into +-pi (two corrections each way), then clamp
   always_comb begin
      w1 = (diff_ff > psc_pkg::PI_Q12)  ? diff_ff - psc_pkg::TWO_PI_Q12 : diff_ff;
      w2 = (w1 > psc_pkg::PI_Q12)       ? w1 - psc_pkg::TWO_PI_Q12      : w1;
      w3 = (w2 < -psc_pkg::PI_Q12)      ? w2 + psc_pkg::TWO_PI_Q12      : w2;
      w4 = (w3 < -psc_pkg::PI_Q12)      ? w3 + psc_pkg::TWO_PI_Q12      : w3;
      lim = psc_pkg::WRAP_W'(angular_limit_ff);
      if (w4 > lim) begin
         clamped = lim;
      end else if (w4 < -lim) begin
         clamped = -lim;
      end else begin
         clamped = w4;
      end
   end

   // response formation in the final step
   always_comb begin
      rsp_lin_in  = rsp_lin_ff;
      rsp_ang_in  = rsp_ang_ff;
      rsp_stop_in = rsp_stop_ff;
      if (len_ff < psc_pkg::LEN_W'(stop_distance_ff)) begin
         rsp_lin_in  = '0;
         rsp_ang_in  = '0;
         rsp_stop_in = 1'b1;
      end else begin
         if (len_ff > psc_pkg::LEN_W'(linear_limit_ff)) begin
            rsp_lin_in = linear_limit_ff;
         end else begin
            rsp_lin_in = len_ff[psc_pkg::CFG_W-1:0];
         end
         rsp_ang_in  = clamped[psc_pkg::ANG_W-1:0];
         rsp_stop_in = 1'b0;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer && req_operation) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            state_in = S_CORDIC;
         end
         S_CORDIC: begin
            if (cordic_status.done) begin
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            state_in = S_WRAP;
         end
         S_WRAP: begin
            // hold until the response register can take the result
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_valid_ff     <= 1'b0;
         stop_distance_ff <= psc_pkg::STOP_DISTANCE_RST;
         linear_limit_ff  <= psc_pkg::LINEAR_LIMIT_RST;
         angular_limit_ff <= psc_pkg::ANGULAR_LIMIT_RST;
         own_x_ff         <= psc_pkg::OWN_POS_RST;
         own_y_ff         <= psc_pkg::OWN_POS_RST;
         own_heading_ff   <= psc_pkg::OWN_HEADING_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               psc_pkg::CSR_STOP_DISTANCE: stop_distance_ff <= csr_wdata;
               psc_pkg::CSR_LINEAR_LIMIT:  linear_limit_ff  <= csr_wdata;
               psc_pkg::CSR_ANGULAR_LIMIT: angular_limit_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         // own pose update transfer
         if (req_xfer && !req_operation) begin
            own_x_ff       <= req_pos_x;
            own_y_ff       <= req_pos_y;
            own_heading_ff <= req_heading;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         dzero_ff <= (dx_in == '0) && (dy_in == '0);
      end
      if (state_ff == S_CORDIC) begin
         prod_ff    <= prod_in;
         bearing_ff <= bearing_in;
      end
      if (state_ff == S_SCALE) begin
         len_ff  <= len_sum[psc_pkg::PROD_W-1:psc_pkg::LEN_SH];
         diff_ff <= diff_in;
      end
      if ((state_ff == S_WRAP) && out_free) begin
         rsp_lin_ff  <= rsp_lin_in;
         rsp_ang_ff  <= rsp_ang_in;
         rsp_stop_ff <= rsp_stop_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_linear_speed  = rsp_lin_ff;
   assign rsp_angular_speed = rsp_ang_ff;
   assign rsp_stopped       = rsp_stop_ff;

   // the rotator is never busy while requests are taken
   a_idle_not_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !cordic_status.busy)
      else $error("rotator busy while sequencer idle");

   // rotator completion only while the sequencer waits for it
   a_done_in_cordic: assert property (@(posedge clock) disable iff (reset)
      cordic_status.done |-> (state_ff == S_CORDIC))
      else $error("rotator done outside its wait state");

   // a target transfer leads in the next cycle to the load step that starts the rotator
   a_target_starts: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_operation) |=> (state_ff == S_LOAD))
      else $error("target transfer did not start the rotation");

   // a new response only leaves the final step
   a_rsp_from_wrap: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_WRAP))
      else $error("response raised outside the final step");

   // a stop response carries a zero command
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stop_ff) |-> ((rsp_lin_ff == '0) && (rsp_ang_ff == '0)))
      else $error("stop response with nonzero command");

endmodule
`default_nettype wire

### hw/rtl/psc_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psc_cordic
// iterative vectoring rotator: one shift-add step per cycle
// ----------------------------------------------------------------------------
module psc_cordic #(
   parameter int CORDIC_ITERATIONS = psc_pkg::CORDIC_ITERATIONS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic signed [psc_pkg::DIFF_W-1:0]    dx,
   input  wire logic signed [psc_pkg::DIFF_W-1:0]    dy,
   output psc_pkg::cordic_status_type                status,
   output logic [psc_pkg::CX_W-2:0]                  x_mag,
   output logic signed [psc_pkg::Z_W-1:0]            z_out
);

   localparam int ITER_W = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
   localparam int EXT_W  = psc_pkg::CX_W - psc_pkg::DIFF_W - psc_pkg::SCALE_SH;

   logic signed [psc_pkg::CX_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [psc_pkg::Z_W-1:0]  z_ff, z_in;
   logic [ITER_W-1:0]               cnt_ff, cnt_in;
   logic                            busy_ff, busy_in, done_ff, done_in;

   logic signed [psc_pkg::CX_W-1:0] x_scaled, y_scaled, xs, ys;
   logic signed [psc_pkg::Z_W-1:0]  atan_val;
   logic                            last_iter;

   assign x_scaled = {{EXT_W{dx[psc_pkg::DIFF_W-1]}}, dx, {psc_pkg::SCALE_SH{1'b0}}};
   assign y_scaled = {{EXT_W{dy[psc_pkg::DIFF_W-1]}}, dy, {psc_pkg::SCALE_SH{1'b0}}};

   // shared shifter and adders
   assign xs        = x_ff >>> cnt_ff;
   assign ys        = y_ff >>> cnt_ff;
   assign atan_val  = psc_pkg::Z_W'(psc_pkg::atan_q20(psc_pkg::ATAN_IDX_W'(cnt_ff)));
   assign last_iter = (cnt_ff == ITER_W'(CORDIC_ITERATIONS - 1));

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // left half plane: pre-rotate by a quarter turn
         if (dx[psc_pkg::DIFF_W-1]) begin
            if (!dy[psc_pkg::DIFF_W-1]) begin
               x_in = y_scaled;
               y_in = -x_scaled;
               z_in = psc_pkg::HALF_PI_Q20;
            end else begin
               x_in = -y_scaled;
               y_in = x_scaled;
               z_in = -psc_pkg::HALF_PI_Q20;
            end
         end else begin
            x_in = x_scaled;
            y_in = y_scaled;
            z_in = '0;
         end
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!y_ff[psc_pkg::CX_W-1]) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_val;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_val;
         end
         cnt_in = cnt_ff + 1'b1;
         if (last_iter) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign x_mag       = x_ff[psc_pkg::CX_W-1] ? '0 : x_ff[psc_pkg::CX_W-2:0];
   assign z_out       = z_ff;

endmodule
`default_nettype wire

### tb/pursuit_steering_command_test.sv
// ----------------------------------------------------------------------------
// pursuit_steering_command_test
// self-checking bench for the go-to-target steering block: a cycle-free
// predictor of the distance, bearing and heading error runs beside the block,
// every response transfer is checked against it, with random stalls on both
// channels and a long response hold-off
// ----------------------------------------------------------------------------
module pursuit_steering_command_test;

   import psc_pkg::*;

   // bench-local codes
   typedef enum logic {
      OP_POSE   = 1'b0,
      OP_TARGET = 1'b1
   } steer_op_e;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [CFG_W-1:0]        linear_speed;
      logic signed [ANG_W-1:0] angular_speed;
      logic                    stopped;
   } steer_cmd_t;

   // fixed-point constants of the steering law
   localparam int     ROTATION_STEPS = CORDIC_ITERATIONS_DEF;
   localparam longint QUARTER_TURN   = 1647099;   // pi/2 in Q.20
   localparam longint RECIP_GAIN     = 39797;     // 1/K in Q16
   localparam longint LEN_HALF       = 8388608;   // rounding term for >> 24
   localparam int     HALF_TURN      = 12868;     // pi in Q3.12
   localparam int     FULL_TURN      = 25736;     // 2*pi in Q3.12
   localparam longint ARCTAN_Q20 [24] = '{
      823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
      4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2, 1, 0, 0, 0
   };

   // run control
   localparam int SETTLE_CYCLES = ROTATION_STEPS + 10;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int HOLD_CYCLES   = 300;
   localparam int MAX_REPORTS   = 10;

   // dut signals, all inputs known from time zero
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_operation = 1'b0;
   logic signed [POS_W-1:0] req_pos_x = '0;
   logic signed [POS_W-1:0] req_pos_y = '0;
   logic signed [ANG_W-1:0] req_heading = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [CFG_W-1:0]        rsp_linear_speed;
   logic signed [ANG_W-1:0] rsp_angular_speed;
   logic                    rsp_stopped;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CFG_W-1:0]        csr_wdata = '0;

   // predictor state: follower pose and register copies
   logic signed [POS_W-1:0] follower_x = OWN_POS_RST;
   logic signed [POS_W-1:0] follower_y = OWN_POS_RST;
   logic signed [ANG_W-1:0] follower_heading = OWN_HEADING_RST;
   logic [CFG_W-1:0]        stop_distance_cfg = STOP_DISTANCE_RST;
   logic [CFG_W-1:0]        linear_limit_cfg = LINEAR_LIMIT_RST;
   logic [CFG_W-1:0]        angular_limit_cfg = ANGULAR_LIMIT_RST;

   steer_cmd_t expected_commands [$];
   steer_cmd_t oldest_command;
   int         mismatch_count = 0;
   bit         steady = 1'b0;          // no idling on either side while set
   bit         receiver_hold = 1'b0;   // request a long response hold-off

   pursuit_steering_command u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_heading       (req_heading),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_linear_speed  (rsp_linear_speed),
      .rsp_angular_speed (rsp_angular_speed),
      .rsp_stopped       (rsp_stopped),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // steering law: updates the pose on a pose item, returns 1 and the
   // command on a target item
   function automatic bit steer_command_for(input steer_op_e op,
                                            input logic signed [POS_W-1:0] px,
                                            input logic signed [POS_W-1:0] py,
                                            input logic signed [ANG_W-1:0] hd,
                                            output steer_cmd_t cmd);
      longint dx, dy, x, y, z, t, xs, ys, len, stop_l, lin_l;
      int     bearing, diff, lim, i, k;
      cmd = '0;
      if (op == OP_POSE) begin
         follower_x       = px;
         follower_y       = py;
         follower_heading = hd;
         return 1'b0;
      end
      dx = longint'(px) - longint'(follower_x);
      dy = longint'(py) - longint'(follower_y);
      x  = dx * 256;
      y  = dy * 256;
      z  = 0;
      // left half plane: turn by a quarter first so the rotation converges
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = QUARTER_TURN;
         end else begin
            t = x; x = -y; y = t; z = -QUARTER_TURN;
         end
      end
      for (i = 0; i < ROTATION_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += ARCTAN_Q20[i];
         end else begin
            x -= ys; y += xs; z -= ARCTAN_Q20[i];
         end
      end
      if (x < 0) x = 0;
      len     = (x * RECIP_GAIN + LEN_HALF) >>> 24;
      bearing = (dx == 0 && dy == 0) ? 0 : int'((z + 128) >>> 8);
      stop_l  = stop_distance_cfg;
      lin_l   = linear_limit_cfg;
      if (len < stop_l) begin
         cmd.stopped = 1'b1;
         return 1'b1;
      end
      if (len > lin_l) len = lin_l;
      diff = bearing - int'(follower_heading);
      for (k = 0; k < 2; k++)
         if (diff > HALF_TURN) diff -= FULL_TURN;
      for (k = 0; k < 2; k++)
         if (diff < -HALF_TURN) diff += FULL_TURN;
      lim = angular_limit_cfg;
      if (diff > lim) diff = lim;
      if (diff < -lim) diff = -lim;
      cmd.linear_speed  = CFG_W'(len);
      cmd.angular_speed = ANG_W'(diff);
      return 1'b1;
   endfunction

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch at %0t: %s", $time, what);
   endtask

   // offer one request and wait for its transfer; valid stays up for a
   // back-to-back item, it only drops for an idle gap
   task automatic send_item(input steer_op_e op,
                            input logic signed [POS_W-1:0] px,
                            input logic signed [POS_W-1:0] py,
                            input logic signed [ANG_W-1:0] hd);
      steer_cmd_t cmd;
      if (!steady && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_pos_x     <= px;
      req_pos_y     <= py;
      req_heading   <= hd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (steer_command_for(op, px, py, hd, cmd))
         expected_commands.push_back(cmd);
   endtask

   // wait for every expected response, then for the rotator to go quiet
   task automatic settle_block();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_commands.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CFG_W-1:0] value);
      settle_block();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_STOP_DISTANCE: stop_distance_cfg = value;
         CSR_LINEAR_LIMIT:  linear_limit_cfg = value;
         CSR_ANGULAR_LIMIT: angular_limit_cfg = value;
         default: ;
      endcase
   endtask

   task automatic send_random_item();
      steer_op_e               op;
      logic signed [POS_W-1:0] px, py;
      logic signed [ANG_W-1:0] hd;
      int                      pick, span;
      op   = ($urandom_range(99) < 25) ? OP_POSE : OP_TARGET;
      hd   = ANG_W'($urandom);
      pick = $urandom_range(99);
      if (op == OP_POSE || pick < 40) begin
         px = POS_W'($urandom);
         py = POS_W'($urandom);
      end else begin
         // targets near the follower reach the stop zone and short vectors
         span = (pick < 75) ? 4096 : 256;
         px = POS_W'(int'(follower_x) + int'($urandom_range(0, span - 1)) - span / 2);
         py = POS_W'(int'(follower_y) + int'($urandom_range(0, span - 1)) - span / 2);
      end
      send_item(op, px, py, hd);
   endtask

   // defaults after reset: zero vector, stop edge, both left-half branches, cap
   task automatic test_reset_defaults();
      send_item(OP_TARGET, 16'sd1024, 16'sd1024, 16'sd0);
      send_item(OP_TARGET, 16'sd2048, 16'sd1024, 16'sd0);
      send_item(OP_TARGET, -16'sd32768, -16'sd32768, 16'sd0);
      send_item(OP_TARGET, -16'sd32768, 16'sd32767, -16'sd1);
      send_item(OP_TARGET, 16'sd32767, 16'sd32767, 16'sd0);
   endtask

   // heading error wrapping in both directions and angular clamping
   task automatic test_heading_wrap();
      send_item(OP_POSE, 16'sd0, 16'sd0, -16'sd32768);
      send_item(OP_TARGET, -16'sd1024, 16'sd16, 16'sd0);      // two subtractions
      send_item(OP_POSE, 16'sd0, 16'sd0, 16'sd32767);
      send_item(OP_TARGET, -16'sd1024, -16'sd16, 16'sd0);     // two additions
      send_item(OP_POSE, 16'sd0, 16'sd0, -16'sd8000);
      send_item(OP_TARGET, 16'sd0, 16'sd1024, 16'sd0);        // single wrap
      send_item(OP_POSE, 16'sd0, 16'sd0, 16'sd0);
      send_item(OP_TARGET, -16'sd1024, 16'sd1024, 16'sd0);    // clamp high
      send_item(OP_TARGET, -16'sd1024, -16'sd1024, 16'sd0);   // clamp low
      send_item(OP_TARGET, 16'sd0, -16'sd2048, 16'sd0);
      // widest difference vectors
      send_item(OP_POSE, 16'sd32767, -16'sd32768, 16'sd0);
      send_item(OP_TARGET, -16'sd32768, 16'sd32767, 16'sd0);
      send_item(OP_POSE, -16'sd32768, 16'sd32767, 16'sd0);
      send_item(OP_TARGET, 16'sd32767, -16'sd32768, 16'sd0);
   endtask

   // register extremes, plus a write to the unused index that must be ignored
   task automatic test_register_extremes();
      write_register(CSR_UNUSED, 15'h7fff);
      send_item(OP_TARGET, 16'sd2048, 16'sd2048, 16'sd0);
      write_register(CSR_STOP_DISTANCE, 15'd0);
      write_register(CSR_LINEAR_LIMIT, 15'h7fff);
      write_register(CSR_ANGULAR_LIMIT, 15'h7fff);
      send_item(OP_TARGET, -16'sd32768, 16'sd32767, 16'sd0);  // zero vector, no stop
      send_item(OP_TARGET, 16'sd32767, -16'sd32768, 16'sd0);
      write_register(CSR_STOP_DISTANCE, 15'h7fff);
      write_register(CSR_LINEAR_LIMIT, 15'd0);
      write_register(CSR_ANGULAR_LIMIT, 15'd0);
      send_item(OP_TARGET, 16'sd32767, -16'sd32768, 16'sd0);  // beyond stop, zero caps
      send_item(OP_TARGET, 16'sd0, 16'sd0, 16'sd0);           // also beyond stop, zero caps
   endtask

   // response side holds off while targets keep coming, input must stall
   task automatic test_backpressure();
      write_register(CSR_STOP_DISTANCE, STOP_DISTANCE_RST);
      write_register(CSR_LINEAR_LIMIT, LINEAR_LIMIT_RST);
      write_register(CSR_ANGULAR_LIMIT, ANGULAR_LIMIT_RST);
      receiver_hold = 1'b1;
      repeat (8) send_item(OP_TARGET, POS_W'($urandom), POS_W'($urandom), '0);
      settle_block();
   endtask

   // random phases under several register settings, first one without idling
   task automatic test_random_traffic();
      int phase;
      for (phase = 0; phase < 4; phase++) begin
         if (phase != 0) begin
            write_register(CSR_STOP_DISTANCE, CFG_W'($urandom_range(0, 4096)));
            write_register(CSR_LINEAR_LIMIT, CFG_W'($urandom_range(512, 32767)));
            write_register(CSR_ANGULAR_LIMIT, CFG_W'($urandom_range(1024, 32767)));
         end
         steady = (phase == 0);
         repeat (100) send_random_item();
      end
      steady = 1'b0;
   endtask

   // response ready: random stalls, or a counted hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (receiver_hold) begin
            rsp_ready <= 1'b0;
            for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clock);
            receiver_hold = 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 7);
         end
      end
   end

   // response checker: each transfer against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_commands.size() == 0) begin
            flag_mismatch($sformatf("unexpected response linear %0d angular %0d stop %0b",
                                    rsp_linear_speed, rsp_angular_speed, rsp_stopped));
         end else begin
            oldest_command = expected_commands.pop_front();
            if (rsp_linear_speed !== oldest_command.linear_speed)
               flag_mismatch($sformatf("linear_speed expected %0d actual %0d",
                                       oldest_command.linear_speed, rsp_linear_speed));
            if (rsp_angular_speed !== oldest_command.angular_speed)
               flag_mismatch($sformatf("angular_speed expected %0d actual %0d",
                                       oldest_command.angular_speed, rsp_angular_speed));
            if (rsp_stopped !== oldest_command.stopped)
               flag_mismatch($sformatf("stopped expected %0b actual %0b",
                                       oldest_command.stopped, rsp_stopped));
         end
      end
   end

   // sequence of tests
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_heading_wrap();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();
      settle_block();
      if (expected_commands.size() != 0)
         flag_mismatch($sformatf("%0d responses never arrived", expected_commands.size()));
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule
